>>> hdl/jokl_pkg.sv
package jokl_pkg;

  localparam int KEY_MAX_CHARS = 8;
  localparam int OFFSET_BITS   = 24;
  localparam int DEPTH_BITS    = 16;
  localparam int KEY_BITS      = 8 * KEY_MAX_CHARS;
  localparam int KLEN_BITS     = 4;
  localparam int OUT_OFF_BITS  = 24;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    PH_OPEN   = 4'd0,
    PH_MEMBER = 4'd1,
    PH_KEY    = 4'd2,
    PH_COLON  = 4'd3,
    PH_VALWS  = 4'd4,
    PH_STR    = 4'd5,
    PH_OBJ    = 4'd6,
    PH_BARE   = 4'd7,
    PH_AFTER  = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

endpackage

>>> hdl/json_object_key_locator_core.sv
// Top-level key lookup over a streamed document.
// Input channel (in_*): one document byte per word in in_tdata, in_tlast on
// the final byte. A zero byte also ends the document for the scanner, but the
// block keeps ignoring bytes until in_tlast.
// Result channel (out_*): at most one word per document, key_found in bit 0
// and value_offset in bits 24:1. It comes in the cycle after the byte that
// decides it (the matching value byte, a malformed byte, or the last byte).
// Throughput: one byte per cycle while in_tready is high; each byte updates
// the scanner state registers and the result lands in the output register.
// Stall: while a result waits in the output register and out_tready is low,
// in_tready drops; bytes that give no result still flow once the slot clears.
// Configuration: cfg_we with cfg_index 0 writes the key characters (first in
// the low byte), cfg_index 1 writes the key length (above 8 counts as 8).
// Write only while idle.
// Reset (rst_n low, synchronous): key and length clear to zero, the scanner
// waits for an opening brace at offset zero, the output slot empties.
module json_object_key_locator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // text_byte
  input  logic                                 in_tlast,   // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [jokl_pkg::OUT_DATA_BITS-1:0]   out_tdata,  // key_found, value_offset
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [jokl_pkg::KEY_BITS-1:0]        cfg_wdata
);
  import jokl_pkg::*;

  logic [KEY_BITS-1:0]     key_bytes_r;
  logic [KLEN_BITS-1:0]    key_len_r;
  phase_t                  phase_r, phase_step, phase_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt, pos_inc;
  logic [3:0]              kidx_r, kidx_step, kidx_nxt;
  logic                    match_r, match_step, match_nxt;
  logic [DEPTH_BITS-1:0]   depth_r, depth_step, depth_nxt;
  logic                    esc_r, esc_step, esc_nxt;
  logic                    out_valid_r;
  logic [OUT_OFF_BITS-1:0] out_off_r, out_off_nxt;
  logic                    out_found_r, out_found_nxt;

  logic                    acc, live, give_step, found_step, give_any;
  logic [KLEN_BITS-1:0]    klen;
  logic [7:0]              c, key_char;
  logic                    ws;

  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign c          = in_tdata;
  assign ws         = (c != CH_NUL) && is_blank(c);
  assign klen       = (key_len_r > KLEN_BITS'(KEY_MAX_CHARS)) ?
                      KLEN_BITS'(KEY_MAX_CHARS) : key_len_r;
  assign key_char   = key_bytes_r[8*kidx_r[2:0] +: 8];
  assign pos_inc    = pos_r + 1'b1;
  assign live       = (phase_r != PH_DONE);

  // next state of the scanner for one byte, ignoring the result
  always_comb begin
    phase_step = phase_r;
    kidx_step  = kidx_r;
    match_step = match_r;
    depth_step = depth_r;
    esc_step   = esc_r;
    unique case (phase_r)
      PH_OPEN: begin
        if (c == CH_LBRACE) phase_step = PH_MEMBER;
      end
      PH_MEMBER, PH_AFTER: begin
        if (ws) begin
          phase_step = (phase_r == PH_AFTER) ? PH_AFTER : PH_MEMBER;
        end else if (phase_r == PH_AFTER && c == CH_COMMA) begin
          phase_step = PH_MEMBER;
        end else if (c == CH_QUOTE) begin
          phase_step = PH_KEY;
          kidx_step  = '0;
          match_step = 1'b1;
        end
      end
      PH_KEY: begin
        if (c == CH_QUOTE) begin
          match_step = match_r && (kidx_r == klen);
          phase_step = PH_COLON;
        end else if (c != CH_NUL) begin
          if (kidx_r >= klen || key_char != c) match_step = 1'b0;
          if (kidx_r != 4'd15) kidx_step = kidx_r + 4'd1;
        end
      end
      PH_COLON: begin
        if (c == CH_COLON) phase_step = PH_VALWS;
      end
      PH_VALWS: begin
        if (!ws && !match_r) begin
          if (c == CH_QUOTE) begin
            phase_step = PH_STR;
            esc_step   = 1'b0;
          end else if (c == CH_LBRACE) begin
            phase_step = PH_OBJ;
            depth_step = DEPTH_BITS'(1);
          end else if (c == CH_COMMA) begin
            phase_step = PH_MEMBER;
          end else begin
            phase_step = PH_BARE;
          end
        end
      end
      PH_STR: begin
        if (c != CH_NUL) begin
          if (esc_r) esc_step = 1'b0;
          else if (c == CH_BSLASH) esc_step = 1'b1;
          else if (c == CH_QUOTE) phase_step = PH_AFTER;
        end
      end
      PH_OBJ: begin
        if (c == CH_LBRACE) begin
          if (depth_r != '1) depth_step = depth_r + 1'b1;
        end else if (c == CH_RBRACE) begin
          if (depth_r != '0) depth_step = depth_r - 1'b1;
          if (depth_r <= DEPTH_BITS'(1)) phase_step = PH_AFTER;
        end
      end
      PH_BARE: begin
        phase_step = (c == CH_COMMA) ? PH_MEMBER : PH_BARE;
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  // result decision for one byte
  always_comb begin
    give_step  = 1'b0;
    found_step = 1'b0;
    unique case (phase_r)
      PH_OPEN:   give_step = !ws && c != CH_LBRACE;
      PH_MEMBER: give_step = !ws && c != CH_QUOTE;
      PH_AFTER:  give_step = !ws && c != CH_QUOTE && c != CH_COMMA;
      PH_KEY:    give_step = (c == CH_NUL);
      PH_COLON:  give_step = !ws && c != CH_COLON;
      PH_VALWS: begin
        if (!ws) begin
          found_step = match_r;
          give_step  = match_r || c == CH_NUL || c == CH_RBRACE;
        end
      end
      PH_STR:    give_step = (c == CH_NUL);
      PH_OBJ:    give_step = (c == CH_NUL);
      PH_BARE:   give_step = (c == CH_NUL) || (c == CH_RBRACE);
      PH_DONE:   give_step = 1'b0;
      default:   give_step = 1'b0;
    endcase
    give_any = live && (give_step || in_tlast);
    if (give_step) begin
      out_found_nxt = found_step;
      out_off_nxt   = found_step ? OUT_OFF_BITS'(pos_r) : '0;
    end else begin
      out_found_nxt = (phase_step == PH_VALWS) && match_step;
      out_off_nxt   = out_found_nxt ? OUT_OFF_BITS'(pos_inc) : '0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    kidx_nxt  = kidx_r;
    match_nxt = match_r;
    depth_nxt = depth_r;
    esc_nxt   = esc_r;
    if (in_tlast) begin
      phase_nxt = PH_OPEN;
      pos_nxt   = '0;
      kidx_nxt  = '0;
      match_nxt = 1'b1;
      depth_nxt = '0;
      esc_nxt   = 1'b0;
    end else if (live) begin
      phase_nxt = give_step ? PH_DONE : phase_step;
      pos_nxt   = pos_inc;
      kidx_nxt  = kidx_step;
      match_nxt = match_step;
      depth_nxt = depth_step;
      esc_nxt   = esc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r <= '0;
      key_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_BYTES:  key_bytes_r <= cfg_wdata;
        REG_KEY_LENGTH: key_len_r   <= cfg_wdata[KLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      pos_r   <= '0;
      kidx_r  <= '0;
      match_r <= 1'b1;
      depth_r <= '0;
      esc_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      kidx_r  <= kidx_nxt;
      match_r <= match_nxt;
      depth_r <= depth_nxt;
      esc_r   <= esc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && give_any) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && give_any) begin
      out_found_r <= out_found_nxt;
      out_off_r   <= out_off_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-OUT_OFF_BITS-1){1'b0}}, out_off_r, out_found_r};

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input stalled with empty output slot");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> phase_r == PH_OPEN && pos_r == '0 && depth_r == '0)
    else $error("document state not cleared after last byte");

  a_depth_in_object: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r != '0 |-> phase_r == PH_OBJ || phase_r == PH_DONE)
    else $error("nesting depth held outside object skip");

  a_done_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_DONE && !in_tlast |-> !give_any)
    else $error("second result in one document");
`endif

endmodule

>>> tb/json_key_lookup_checker.sv
module json_key_lookup_checker
  import jokl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [7:0]               in_tdata,   // text_byte
  input  logic                     in_tlast,   // last_byte
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,  // key_found, value_offset
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [KEY_BITS-1:0]      cfg_wdata,
  output int                       mismatches,
  output int                       words_due
);

  typedef struct packed {
    logic                    found;
    logic [OUT_OFF_BITS-1:0] offset;
  } lookup_t;

  lookup_t located_q[$];
  lookup_t want;

  logic [KEY_BITS-1:0]     key_chars;
  logic [KLEN_BITS-1:0]    key_len;
  phase_t                  scan_ph;
  logic [OFFSET_BITS-1:0]  byte_at;
  logic [KLEN_BITS-1:0]    kidx;
  logic                    kmatch;
  logic [DEPTH_BITS-1:0]   depth;
  logic                    esc;
  logic                    answered;

  logic                    res_hit;
  logic                    res_found;
  logic [OUT_OFF_BITS-1:0] res_off;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic void restart_doc();
    scan_ph  = PH_OPEN;
    byte_at  = '0;
    kidx     = '0;
    kmatch   = 1'b1;
    depth    = '0;
    esc      = 1'b0;
    answered = 1'b0;
  endfunction

  function automatic void settle(logic found, logic [OUT_OFF_BITS-1:0] off);
    res_hit   = 1'b1;
    res_found = found;
    res_off   = found ? off : '0;
    answered  = 1'b1;
    scan_ph   = PH_DONE;
  endfunction

  function automatic void member_start(logic [7:0] c);
    if (is_space(c)) begin
      scan_ph = PH_MEMBER;
    end else if (c == CH_QUOTE) begin
      scan_ph = PH_KEY;
      kidx    = '0;
      kmatch  = 1'b1;
    end else begin
      settle(1'b0, '0);
    end
  endfunction

  function automatic void bare_value(logic [7:0] c);
    if (c == CH_NUL || c == CH_RBRACE) settle(1'b0, '0);
    else scan_ph = (c == CH_COMMA) ? PH_MEMBER : PH_BARE;
  endfunction

  function automatic void scan(logic [7:0] c);
    logic [KLEN_BITS-1:0] klen;
    klen = key_len;
    if (klen > KEY_MAX_CHARS) klen = KLEN_BITS'(KEY_MAX_CHARS);
    case (scan_ph)
      PH_OPEN: begin
        if (c == CH_LBRACE) scan_ph = PH_MEMBER;
        else if (!is_space(c)) settle(1'b0, '0);
      end
      PH_MEMBER: member_start(c);
      PH_KEY: begin
        if (c == CH_NUL) begin
          settle(1'b0, '0);
        end else if (c == CH_QUOTE) begin
          kmatch  = kmatch && (kidx == klen);
          scan_ph = PH_COLON;
        end else begin
          if (kidx >= klen || key_chars[{kidx[2:0], 3'b000} +: 8] != c) kmatch = 1'b0;
          if (kidx != '1) kidx = kidx + 1'b1;
        end
      end
      PH_COLON: begin
        if (c == CH_COLON) scan_ph = PH_VALWS;
        else if (!is_space(c)) settle(1'b0, '0);
      end
      PH_VALWS: begin
        if (!is_space(c)) begin
          if (kmatch) begin
            settle(1'b1, byte_at[OUT_OFF_BITS-1:0]);
          end else if (c == CH_QUOTE) begin
            scan_ph = PH_STR;
            esc     = 1'b0;
          end else if (c == CH_LBRACE) begin
            scan_ph = PH_OBJ;
            depth   = DEPTH_BITS'(1);
          end else begin
            bare_value(c);
          end
        end
      end
      PH_STR: begin
        if (c == CH_NUL) settle(1'b0, '0);
        else if (esc) esc = 1'b0;
        else if (c == CH_BSLASH) esc = 1'b1;
        else if (c == CH_QUOTE) scan_ph = PH_AFTER;
      end
      PH_OBJ: begin
        if (c == CH_NUL) begin
          settle(1'b0, '0);
        end else if (c == CH_LBRACE) begin
          if (depth != '1) depth = depth + 1'b1;
        end else if (c == CH_RBRACE) begin
          if (depth != '0) depth = depth - 1'b1;
          if (depth == '0) scan_ph = PH_AFTER;
        end
      end
      PH_BARE: bare_value(c);
      PH_AFTER: begin
        if (c == CH_COMMA) scan_ph = PH_MEMBER;
        else if (!is_space(c)) member_start(c);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] c, logic last);
    logic [OFFSET_BITS-1:0] next_at;
    res_hit = 1'b0;
    if (!answered) begin
      next_at = byte_at + 1'b1;
      scan(c);
      byte_at = next_at;
      if (!res_hit && last)
        settle(scan_ph == PH_VALWS && kmatch, next_at[OUT_OFF_BITS-1:0]);
    end
    if (last) restart_doc();
  endfunction

  function automatic void report(string what, lookup_t exp_w);
    if (mismatches < 10)
      $display("%s: expected found=%0d offset=%0d, got found=%0d offset=%0d", what,
               exp_w.found, exp_w.offset, out_tdata[0], out_tdata[OUT_OFF_BITS:1]);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_chars = '0;
      key_len   = '0;
      restart_doc();
      located_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_BYTES) key_chars = cfg_wdata;
        else key_len = cfg_wdata[KLEN_BITS-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (located_q.size() == 0) begin
          report("unexpected result word", '0);
        end else begin
          want = located_q.pop_front();
          if (out_tdata[0] != want.found || out_tdata[OUT_OFF_BITS:1] != want.offset)
            report("result word mismatch", want);
        end
      end
      if (in_tvalid && in_tready) begin
        take_byte(in_tdata, in_tlast);
        if (res_hit) begin
          want.found  = res_found;
          want.offset = res_off;
          located_q.push_back(want);
        end
      end
    end
    words_due <= located_q.size();
  end

endmodule

>>> tb/json_object_key_locator_core_tb.sv
module json_object_key_locator_core_tb;
  import jokl_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          RANDOM_BYTES = 1200;
  localparam logic [31:0] BLANK_SET = 32'h0D0A0920;
  localparam logic [63:0] BARE_SET = "-.019eft";

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata = '0;   // text_byte
  logic                     in_tlast = 1'b0; // last_byte
  logic                     out_tvalid;
  logic                     out_tready = 1'b1;
  logic [OUT_DATA_BITS-1:0] out_tdata;       // key_found, value_offset
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = REG_KEY_BYTES;
  logic [KEY_BITS-1:0]      cfg_wdata = '0;

  int mismatches;
  int words_due;

  logic [7:0]          doc_q[$];
  logic [KEY_BITS-1:0] key_now;
  int                  key_use;
  bit                  calm_tx;
  int                  random_bytes = 0;
  int                  idle_run = 0;
  int                  rx_hold = 0;
  int                  rx_calm = 0;
  int                  rx_roll;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  json_object_key_locator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  json_key_lookup_checker lookup_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .words_due(words_due)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm_tx || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_QUOTE) ? "_" : c;
  endfunction

  function automatic void add_ws();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) doc_q.push_back(BLANK_SET[8 * $urandom_range(0, 3) +: 8]);
  endfunction

  function automatic void push_key(int n);
    int i;
    for (i = 0; i < n; i++) doc_q.push_back(key_now[8 * i +: 8]);
  endfunction

  function automatic void start_doc(string s);
    int i;
    doc_q.delete();
    for (i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  function automatic void add_name();
    int pick, n;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      push_key(key_use);
    end else if (pick == 4) begin
      push_key(key_use == 0 ? 0 : key_use - 1);
    end else if (pick == 5) begin
      push_key(key_use);
      doc_q.push_back(name_char());
    end else if (pick == 6 && key_use != 0) begin
      push_key(key_use);
      n = doc_q.size() - key_use + $urandom_range(0, key_use - 1);
      doc_q[n] = name_char();
    end else begin
      n = $urandom_range(0, 9);
      repeat (n) doc_q.push_back(name_char());
    end
  endfunction

  function automatic void add_value();
    int n, lvl, k;
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: begin
        doc_q.push_back(CH_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            doc_q.push_back(CH_BSLASH);
            doc_q.push_back(8'($urandom_range(32, 126)));
          end else begin
            c = name_char();
            doc_q.push_back(c == CH_BSLASH ? "/" : c);
          end
        end
        doc_q.push_back(CH_QUOTE);
      end
      1: begin
        doc_q.push_back(CH_LBRACE);
        lvl = 1;
        n = $urandom_range(0, 10);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: begin
              doc_q.push_back(CH_LBRACE);
              lvl++;
            end
            1: begin
              if (lvl > 1) begin
                doc_q.push_back(CH_RBRACE);
                lvl--;
              end
            end
            default: begin
              c = 8'($urandom_range(32, 126));
              if (c != CH_LBRACE && c != CH_RBRACE) doc_q.push_back(c);
            end
          endcase
        end
        repeat (lvl) doc_q.push_back(CH_RBRACE);
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          k = $urandom_range(0, 7);
          doc_q.push_back(BARE_SET[8 * k +: 8]);
        end
      end
    endcase
  endfunction

  function automatic void make_doc();
    int n, i;
    doc_q.delete();
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 12);
      repeat (n) doc_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_ws();
    doc_q.push_back(CH_LBRACE);
    add_ws();
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      doc_q.push_back(CH_QUOTE);
      add_name();
      doc_q.push_back(CH_QUOTE);
      add_ws();
      doc_q.push_back(CH_COLON);
      add_ws();
      add_value();
      add_ws();
      if (i != n - 1 && $urandom_range(0, 9) != 0) begin
        doc_q.push_back(CH_COMMA);
        add_ws();
      end
    end
    doc_q.push_back(CH_RBRACE);
    repeat ($urandom_range(0, 3)) doc_q.push_back(name_char());
    if ($urandom_range(0, 7) == 0)
      doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, doc_q.size());
      while (doc_q.size() > n) void'(doc_q.pop_back());
    end
  endfunction

  function automatic logic [KEY_BITS-1:0] text_key();
    logic [KEY_BITS-1:0] k;
    int i;
    for (i = 0; i < KEY_MAX_CHARS; i++) k[8 * i +: 8] = name_char();
    return k;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic feed_document(bit force_calm);
    int i;
    calm_tx = force_calm || ($urandom_range(0, 3) == 0);
    for (i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
  endtask

  task automatic settle_idle();
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [KEY_BITS-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_key(logic [KEY_BITS-1:0] chars, int len);
    logic [KEY_BITS-1:0] len_word;
    settle_idle();
    key_now = chars;
    key_use = (len > KEY_MAX_CHARS) ? KEY_MAX_CHARS : len;
    len_word = {$urandom, $urandom};
    len_word[KLEN_BITS-1:0] = len[KLEN_BITS-1:0];
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_KEY_BYTES, chars);
      write_reg(REG_KEY_LENGTH, len_word);
    end else begin
      write_reg(REG_KEY_LENGTH, len_word);
      write_reg(REG_KEY_BYTES, chars);
    end
  endtask

  always @(negedge clk) begin
    rx_roll = $urandom_range(0, 99);
    if (rx_calm != 0) rx_calm--;
    if (rx_hold != 0) begin
      rx_hold--;
    end else if (rx_calm == 0) begin
      if (rx_roll < 12) rx_hold = $urandom_range(1, 3);
      else if (rx_roll < 14) rx_hold = $urandom_range(8, 40);
      else if (rx_roll < 15) rx_calm = $urandom_range(20, 80);
    end
    out_tready <= (rx_hold == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int phase_no;
    int i;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // short documents around the edge cases, key "a"
    load_key(KEY_BITS'("a"), 1);
    start_doc("");
    doc_q.push_back(8'hFF);
    feed_document(1'b0);
    start_doc("{}");
    feed_document(1'b0);
    start_doc("{\"a\": ");
    feed_document(1'b0);
    start_doc("{\"a\":");
    doc_q.push_back(CH_NUL);
    feed_document(1'b0);
    start_doc("{\"b\":\"\\");
    doc_q.push_back(CH_NUL);
    feed_document(1'b0);

    // nested value skipped by brace counting, then the wanted member
    load_key(KEY_BITS'("id"), 2);
    start_doc("{\"q\":");
    for (i = 0; i < 24; i++) doc_q.push_back(CH_LBRACE);
    for (i = 0; i < 24; i++) doc_q.push_back(CH_RBRACE);
    doc_q.push_back(CH_COMMA);
    doc_q.push_back(CH_QUOTE);
    push_key(2);
    doc_q.push_back(CH_QUOTE);
    doc_q.push_back(CH_COLON);
    doc_q.push_back("7");
    doc_q.push_back(CH_RBRACE);
    feed_document(1'b1);

    phase_no = 0;
    while (random_bytes < RANDOM_BYTES) begin
      case (phase_no % 6)
        0: load_key({$urandom, $urandom}, 0);
        1: load_key('1, KEY_MAX_CHARS);
        2: load_key(text_key(), 15);
        3: load_key('0, 2);
        4: load_key(text_key(), $urandom_range(1, 7));
        default: load_key({$urandom, $urandom}, $urandom_range(0, 15));
      endcase
      repeat (8) begin
        make_doc();
        feed_document(1'b0);
        random_bytes += doc_q.size();
      end
      phase_no++;
    end

    while (words_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && words_due == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
